// ===== rtl/core/mptw_pkg.sv =====
`default_nettype none

package mptw_pkg;

  // Table geometry
  localparam int unsigned LevelsDefault = 4;
  localparam int unsigned IdxBits       = 9;
  localparam int unsigned PageOffset    = 12;
  localparam int unsigned EntryShift    = 3;  // 8 bytes per entry
  localparam int unsigned PpnBits       = 52;
  localparam int unsigned PpnLsb        = 10;
  localparam int unsigned PermFields    = 16;
  localparam int unsigned PermLsb       = 2;
  localparam int unsigned ShiftLevels   = 4;

  // Reset values of the page shift registers
  localparam logic [5:0] Shift0Reset = 6'd12;
  localparam logic [5:0] Shift1Reset = 6'd21;
  localparam logic [5:0] Shift2Reset = 6'd30;
  localparam logic [5:0] Shift3Reset = 6'd39;

  // Entry bits
  localparam int unsigned EntryValidBit = 0;
  localparam int unsigned EntryLeafBit  = 1;

  typedef enum logic {
    ModeStart = 1'b0,
    ModeData  = 1'b1
  } mptw_mode_e;

  typedef enum logic [1:0] {
    AccRead  = 2'd0,
    AccWrite = 2'd1,
    AccExec  = 2'd2,
    AccOther = 2'd3
  } mptw_access_e;

  typedef enum logic {
    RsltReadReq = 1'b0,
    RsltAnswer  = 1'b1
  } mptw_result_e;

  typedef enum logic [2:0] {
    CfgRootPpn = 3'd0,
    CfgShift0  = 3'd1,
    CfgShift1  = 3'd2,
    CfgShift2  = 3'd3,
    CfgShift3  = 3'd4
  } mptw_cfg_idx_e;

  typedef struct packed {
    logic        result_kind;
    logic [63:0] read_addr;
    logic        leaf_found;
    logic        allowed;
    logic [63:0] leaf_entry;
    logic [1:0]  leaf_level;
  } mptw_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/mptw_if.sv =====
`default_nettype none

interface mptw_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] phys_addr;
  logic [1:0]  access_kind;
  logic [63:0] read_data;

  modport source (output valid, output mode, output phys_addr, output access_kind,
                  output read_data, input ready);
  modport sink   (input valid, input mode, input phys_addr, input access_kind,
                  input read_data, output ready);
endinterface

interface mptw_rsp_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [63:0] read_addr;
  logic        leaf_found;
  logic        allowed;
  logic [63:0] leaf_entry;
  logic [1:0]  leaf_level;

  modport source (output valid, output result_kind, output read_addr, output leaf_found,
                  output allowed, output leaf_entry, output leaf_level, input ready);
  modport sink   (input valid, input result_kind, input read_addr, input leaf_found,
                  input allowed, input leaf_entry, input leaf_level, output ready);
endinterface

interface mptw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mptw_out_fifo.sv =====
`default_nettype none

// Two-word result buffer: lets the walker keep taking words while one waits.
module mptw_out_fifo
  import mptw_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  output logic           space_o,
  input  wire logic      push_i,
  input  wire mptw_rsp_t push_data_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output mptw_rsp_t      data_o
);

  mptw_rsp_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign space_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/memory_protection_table_walker.sv =====
`default_nettype none

// Memory protection table walker.
// req_i takes words of two kinds: mode start latches an address and access
// kind and begins a walk at the top level; mode data hands back the table
// entry that the last read request asked for. rsp_o gives one word per start
// and per data word taken during a walk: either a table read request with the
// entry address, or the final answer (leaf found, allowed, raw leaf, level).
// A data word while no walk runs gives nothing; a start during a walk drops it.
// cfg_i writes the root page number and the four per-level page shifts; it is
// always ready. The user must write it only while the walker is idle; the
// block itself does not enforce this. Response words are registered in the
// result buffer. Throughput: one word per cycle while the buffer has space,
// set by the single pass of index select, entry add and permission pick
// between the walk state and the result buffer. When rsp_o stalls, the
// two-word buffer absorbs results; req_i ready drops only once both are held.
// Reset: walker idle, buffer empty, root page 0, shifts 12/21/30/39.
module memory_protection_table_walker
  import mptw_pkg::*;
#(
  parameter int unsigned LEVELS = LevelsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mptw_req_if.sink   req_i,
  mptw_cfg_if.sink   cfg_i,
  mptw_rsp_if.source rsp_o
);

  localparam int unsigned LvlW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // Configuration
  logic [PpnBits-1:0] root_ppn_q;
  logic [5:0]         shift_q [ShiftLevels];

  // Walk state
  logic               busy_q, busy_d;
  logic [LvlW-1:0]    level_q, level_d;
  logic [63:0]        addr_q, addr_d;
  logic [1:0]         kind_q, kind_d;
  logic [PpnBits-1:0] ppn_q, ppn_d;     // table base is ppn << 12

  logic      space;
  logic      req_fire;
  logic      has_rslt;
  mptw_rsp_t rslt;
  mptw_rsp_t buf_data;

  logic [IdxBits-1:0] idx;
  logic [63:0]        entry_addr;
  logic [2:0]         lvl3;
  logic [63:0]        sh_addr;
  logic [3:0]         pi;
  logic [2:0]         perm;
  logic               grant;
  logic [63:0]        ent;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = space;
  assign req_fire    = req_i.valid && space;
  assign ent         = req_i.read_data;

  // Config writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_ppn_q <= '0;
      shift_q[0] <= Shift0Reset;
      shift_q[1] <= Shift1Reset;
      shift_q[2] <= Shift2Reset;
      shift_q[3] <= Shift3Reset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgRootPpn: root_ppn_q <= cfg_i.data[PpnBits-1:0];
        CfgShift0:  shift_q[0] <= cfg_i.data[5:0];
        CfgShift1:  shift_q[1] <= cfg_i.data[5:0];
        CfgShift2:  shift_q[2] <= cfg_i.data[5:0];
        CfgShift3:  shift_q[3] <= cfg_i.data[5:0];
        default: ;
      endcase
    end
  end

  // Permission pick on the current walk state
  always_comb begin
    lvl3    = 3'(level_q);
    sh_addr = addr_q >> shift_q[lvl3[1:0]];
    pi      = sh_addr[3:0];
    perm    = '0;
    for (int f = 0; f < PermFields; f++) begin
      if (pi == 4'(f)) perm = ent[PermLsb + 3*f +: 3];
    end
    if (lvl3 > 3'd3) begin
      grant = 1'b0;  // no page shift above level three
    end else begin
      unique case (kind_q)
        AccRead:  grant = perm[0];
        AccWrite: grant = perm[1];
        AccExec:  grant = perm[2];
        default:  grant = 1'b0;
      endcase
    end
  end

  // Next walk state, then entry address from the next state
  always_comb begin
    busy_d   = busy_q;
    level_d  = level_q;
    addr_d   = addr_q;
    kind_d   = kind_q;
    ppn_d    = ppn_q;
    has_rslt = 1'b0;
    rslt     = '0;
    if (req_i.mode == ModeStart) begin
      busy_d           = 1'b1;
      level_d          = LvlW'(LEVELS - 1);
      addr_d           = req_i.phys_addr;
      kind_d           = req_i.access_kind;
      ppn_d            = root_ppn_q;
      has_rslt         = 1'b1;
      rslt.result_kind = RsltReadReq;
    end else if (busy_q) begin
      has_rslt = 1'b1;
      priority if (!ent[EntryValidBit]) begin
        busy_d           = 1'b0;
        rslt.result_kind = RsltAnswer;
      end else if (ent[EntryLeafBit]) begin
        busy_d           = 1'b0;
        rslt.result_kind = RsltAnswer;
        rslt.leaf_found  = 1'b1;
        rslt.allowed     = grant;
        rslt.leaf_entry  = ent;
        rslt.leaf_level  = lvl3[1:0];
      end else if (level_q == '0) begin
        busy_d           = 1'b0;
        rslt.result_kind = RsltAnswer;
      end else begin
        level_d          = level_q - LvlW'(1);
        ppn_d            = ent[PpnLsb +: PpnBits];
        rslt.result_kind = RsltReadReq;
      end
    end

    idx = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (level_d == LvlW'(l)) idx = addr_d[IdxBits*l + PageOffset +: IdxBits];
    end
    entry_addr = {ppn_d, {PageOffset{1'b0}}} + (64'(idx) << EntryShift);
    if (rslt.result_kind == RsltReadReq) begin
      rslt.read_addr = entry_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      level_q <= '0;
      addr_q  <= '0;
      kind_q  <= '0;
      ppn_q   <= '0;
    end else if (req_fire) begin
      busy_q  <= busy_d;
      level_q <= level_d;
      addr_q  <= addr_d;
      kind_q  <= kind_d;
      ppn_q   <= ppn_d;
    end
  end

  mptw_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .space_o     (space),
    .push_i      (req_fire && has_rslt),
    .push_data_i (rslt),
    .valid_o     (rsp_o.valid),
    .ready_i     (rsp_o.ready),
    .data_o      (buf_data)
  );

  assign rsp_o.result_kind = buf_data.result_kind;
  assign rsp_o.read_addr   = buf_data.read_addr;
  assign rsp_o.leaf_found  = buf_data.leaf_found;
  assign rsp_o.allowed     = buf_data.allowed;
  assign rsp_o.leaf_entry  = buf_data.leaf_entry;
  assign rsp_o.leaf_level  = buf_data.leaf_level;

endmodule

`default_nettype wire
